// ----- rtl/ball_beam_plant_emulator_defines.svh -----
// ----------------------------------------------------------------------------
// Ball and beam plant emulator - assertion macros
// Shared concurrent check forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef BALL_BEAM_PLANT_EMULATOR_DEFINES_SVH
`define BALL_BEAM_PLANT_EMULATOR_DEFINES_SVH

// Same-cycle implication.
`define BBPE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bbpe: same-cycle check failed");

// Next-cycle implication.
`define BBPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bbpe: next-cycle check failed");

`endif

// ----- rtl/bbpe_pkg.sv -----
// ----------------------------------------------------------------------------
// bbpe_pkg
// Constants, config register map and fixed-point helpers for the emulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbpe_pkg;

  // Number formats
  localparam int FRAC_BITS      = 16;
  localparam int COEF_FRAC_BITS = 30;
  localparam int PWM_BITS       = 12;
  localparam int SPLIT_BITS     = 20;

  localparam int CNT_W     = 16;
  localparam int COEF_W    = 32;
  localparam int STATE_W   = 48;
  localparam int SETPT_W   = CNT_W + 1;
  localparam int XIN_W     = SETPT_W + FRAC_BITS;
  localparam int BEAM_W    = PWM_BITS + FRAC_BITS;
  localparam int Y_W       = STATE_W + 2;
  localparam int HI_W      = STATE_W - SPLIT_BITS;
  localparam int HI_PROD_W = COEF_W + HI_W;
  localparam int LO_PROD_W = COEF_W + SPLIT_BITS + 1;
  localparam int SUM_W     = HI_PROD_W + 4;
  localparam int LO_SUM_W  = LO_PROD_W + 3;
  localparam int TEN_W     = STATE_W + 4;
  localparam int TENTHS_W  = 16;

  // Full scale of the beam output, (2^PWM_BITS - 1) / 2
  localparam logic signed [BEAM_W-1:0] FULL_SCALE =
    BEAM_W'(((64'sd1 <<< PWM_BITS) - 64'sd1) <<< (FRAC_BITS - 1));
  localparam logic signed [BEAM_W-1:0] NEG_FULL_SCALE = -FULL_SCALE;

  // Config register map
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_OFFSET  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_C        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_E        = 3'd5;

  // Config reset values
  localparam logic [CNT_W-1:0]         SAMPLE_PERIOD_RST = 16'd100;
  localparam logic [CNT_W-1:0]         PULSE_OFFSET_RST  = 16'd510;
  localparam logic signed [COEF_W-1:0] COEF_A_RST        = 32'sd2265;
  localparam logic signed [COEF_W-1:0] COEF_B_RST        = -32'sd2144728749;
  localparam logic signed [COEF_W-1:0] COEF_C_RST        = 32'sd1070989194;
  localparam logic signed [COEF_W-1:0] COEF_E_RST        = 32'sd29450;

  // Split product: coefficient times upper and lower parts of a state word
  typedef struct packed {
    logic signed [HI_PROD_W-1:0] hi;
    logic signed [LO_PROD_W-1:0] lo;
  } part_prod_t;

  function automatic part_prod_t part_mul(input logic signed [COEF_W-1:0] c,
                                          input logic signed [STATE_W-1:0] s);
    part_prod_t p;
    logic signed [HI_W-1:0] hi;
    logic signed [SPLIT_BITS:0] lo;
    hi = s[STATE_W-1:SPLIT_BITS];
    lo = {1'b0, s[SPLIT_BITS-1:0]};
    p.hi = HI_PROD_W'(c * hi);
    p.lo = LO_PROD_W'(c * lo);
    return p;
  endfunction

  // floor((hi*2^SPLIT + lo) / 2^COEF_FRAC_BITS), saturated to STATE_W
  function automatic logic signed [STATE_W-1:0] combine_sat(
      input logic signed [SUM_W-1:0] hi_sum,
      input logic signed [LO_SUM_W-1:0] lo_sum);
    logic signed [SUM_W-1:0] lo_ext;
    logic signed [SUM_W-1:0] tot;
    logic signed [SUM_W-1:0] sh;
    logic signed [STATE_W-1:0] res;
    lo_ext = SUM_W'(lo_sum);
    tot    = hi_sum + (lo_ext >>> SPLIT_BITS);
    sh     = tot >>> (COEF_FRAC_BITS - SPLIT_BITS);
    if ((sh[SUM_W-1:STATE_W-1] == '0) || (sh[SUM_W-1:STATE_W-1] == '1)) begin
      res = sh[STATE_W-1:0];
    end else if (sh[SUM_W-1]) begin
      res = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(STATE_W-1){1'b1}}};
    end
    return res;
  endfunction

  // Servo output times ten, truncated toward zero, saturated to 16 bits
  function automatic logic signed [TENTHS_W-1:0] to_tenths(
      input logic signed [STATE_W-1:0] v);
    logic signed [TEN_W-1:0] ext;
    logic signed [TEN_W-1:0] prod;
    logic signed [TEN_W-1:0] adj;
    logic signed [TEN_W-1:0] q;
    logic signed [TENTHS_W-1:0] res;
    ext  = TEN_W'(v);
    prod = (ext <<< 3) + (ext <<< 1);
    adj  = prod[TEN_W-1] ? prod + TEN_W'((64'sd1 <<< FRAC_BITS) - 64'sd1) : prod;
    q    = adj >>> FRAC_BITS;
    if ((q[TEN_W-1:TENTHS_W-1] == '0) || (q[TEN_W-1:TENTHS_W-1] == '1)) begin
      res = q[TENTHS_W-1:0];
    end else if (q[TEN_W-1]) begin
      res = {1'b1, {(TENTHS_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(TENTHS_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// ----- rtl/ball_beam_plant_emulator.sv -----
// ----------------------------------------------------------------------------
// ball_beam_plant_emulator
// Tick-driven ball and beam plant: pulse width capture, servo and beam model.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per microsecond tick with the three pin levels.
//   out_* : one result request per tick (PWM level, toggle pin, servo output
//           in tenths, sample flag). valid/ready on both sides.
//   cfg_* : register writes (index, data), always ready; write only while idle.
// Flow: a tick taken into the input register is loaded into the result
//   registers once the output side is free; out_valid rises with that load.
// Throughput: one tick per cycle while out_ready is high. The whole servo
//   and beam update (eight split partial products, sums, saturation,
//   clamp) sits in one stage between input register and model/result registers.
// Stall: with out_ready low the result holds; the input register still takes
//   one more tick, then in_ready drops until the result is taken.
// Reset (rst_n low, synchronous): model state and config return to defaults,
//   both stages empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ball_beam_plant_emulator_defines.svh"

module ball_beam_plant_emulator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // tick input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_pulse_level,
  input  logic                                 in_perturb_level,
  input  logic                                 in_calib_level,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bbpe_pkg::PWM_BITS-1:0]        out_pwm_level,
  output logic                                 out_sample_toggle,
  output logic signed [bbpe_pkg::TENTHS_W-1:0] out_servo_tenths,
  output logic                                 out_sampled,
  // config writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bbpe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bbpe_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CNT_W   = bbpe_pkg::CNT_W;
  localparam int COEF_W  = bbpe_pkg::COEF_W;
  localparam int STATE_W = bbpe_pkg::STATE_W;
  localparam int BEAM_W  = bbpe_pkg::BEAM_W;
  localparam int Y_W     = bbpe_pkg::Y_W;
  localparam int SUM_W   = bbpe_pkg::SUM_W;
  localparam int LO_SUM_W = bbpe_pkg::LO_SUM_W;
  localparam int XIN_W   = bbpe_pkg::XIN_W;
  localparam int SETPT_W = bbpe_pkg::SETPT_W;
  localparam int FRAC_BITS = bbpe_pkg::FRAC_BITS;
  localparam int PWM_BITS  = bbpe_pkg::PWM_BITS;

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]         period_r;
  logic [CNT_W-1:0]         offset_r;
  logic signed [COEF_W-1:0] coef_a_r;
  logic signed [COEF_W-1:0] coef_b_r;
  logic signed [COEF_W-1:0] coef_c_r;
  logic signed [COEF_W-1:0] coef_e_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= bbpe_pkg::SAMPLE_PERIOD_RST;
      offset_r <= bbpe_pkg::PULSE_OFFSET_RST;
      coef_a_r <= bbpe_pkg::COEF_A_RST;
      coef_b_r <= bbpe_pkg::COEF_B_RST;
      coef_c_r <= bbpe_pkg::COEF_C_RST;
      coef_e_r <= bbpe_pkg::COEF_E_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bbpe_pkg::CFG_SAMPLE_PERIOD: period_r <= cfg_data[CNT_W-1:0];
        bbpe_pkg::CFG_PULSE_OFFSET:  offset_r <= cfg_data[CNT_W-1:0];
        bbpe_pkg::CFG_COEF_A:        coef_a_r <= cfg_data[COEF_W-1:0];
        bbpe_pkg::CFG_COEF_B:        coef_b_r <= cfg_data[COEF_W-1:0];
        bbpe_pkg::CFG_COEF_C:        coef_c_r <= cfg_data[COEF_W-1:0];
        bbpe_pkg::CFG_COEF_E:        coef_e_r <= cfg_data[COEF_W-1:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register and handshake
  // --------------------------------------------------------------------------
  logic s1_valid_r;
  logic s1_pulse_r;
  logic s1_perturb_r;
  logic s1_calib_r;
  logic out_valid_r;
  logic load;

  // tick moves from input register into the model/result registers
  assign load     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (load) begin
        s1_valid_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pin payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pulse_r   <= in_pulse_level;
      s1_perturb_r <= in_perturb_level;
      s1_calib_r   <= in_calib_level;
    end
  end

  // --------------------------------------------------------------------------
  // Model state (doubles as the result register)
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]          tick_r,     tick_nxt;
  logic                      pulse_prev_r, pulse_prev_nxt;
  logic [CNT_W-1:0]          width_r,    width_nxt;
  logic signed [SETPT_W-1:0] setpt_r,    setpt_nxt;
  logic signed [XIN_W-1:0]   xin0_r,     xin0_nxt;
  logic signed [XIN_W-1:0]   xin1_r,     xin1_nxt;
  logic signed [STATE_W-1:0] sout0_r,    sout0_nxt;
  logic signed [STATE_W-1:0] sout1_r,    sout1_nxt;
  logic signed [BEAM_W-1:0]  beam0_r,    beam0_nxt;
  logic signed [BEAM_W-1:0]  beam1_r,    beam1_nxt;
  logic signed [BEAM_W-1:0]  applied_beam_r, applied_beam_nxt;
  logic [PWM_BITS-1:0]       pwm_r,      pwm_nxt;
  logic                      kick_sign_r, kick_sign_nxt;
  logic                      perturb_prev_r, perturb_prev_nxt;
  logic                      toggle_r,   toggle_nxt;
  logic                      pin_r,      pin_nxt;
  logic                      sampled_r;

  // --------------------------------------------------------------------------
  // Update logic
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]          width_inc;
  logic [CNT_W-1:0]          tick_inc;
  logic                      sample;
  bbpe_pkg::part_prod_t      pa, pb, pc, pe;
  logic signed [SUM_W-1:0]   hi_servo;
  logic signed [LO_SUM_W-1:0] lo_servo;
  logic signed [STATE_W-1:0] sv;
  logic signed [STATE_W-1:0] eterm;
  logic signed [Y_W-1:0]     y_raw;
  logic signed [Y_W-1:0]     y_sel;
  logic signed [BEAM_W-1:0]  y_cl;
  logic [BEAM_W-1:0]         y_pos;

  // four coefficient products, each split into two partial products
  assign pa = bbpe_pkg::part_mul(coef_a_r, STATE_W'(xin1_r));
  assign pb = bbpe_pkg::part_mul(coef_b_r, sout0_r);
  assign pc = bbpe_pkg::part_mul(coef_c_r, sout1_r);
  assign pe = bbpe_pkg::part_mul(coef_e_r, sout1_r);

  assign hi_servo = SUM_W'(pa.hi) - SUM_W'(pb.hi) - SUM_W'(pc.hi);
  assign lo_servo = LO_SUM_W'(pa.lo) - LO_SUM_W'(pb.lo) - LO_SUM_W'(pc.lo);
  assign sv       = bbpe_pkg::combine_sat(hi_servo, lo_servo);
  assign eterm    = bbpe_pkg::combine_sat(SUM_W'(pe.hi), LO_SUM_W'(pe.lo));

  // double integrator
  assign y_raw = (Y_W'(beam0_r) <<< 1) - Y_W'(beam1_r) + Y_W'(eterm);

  always_comb begin
    // pulse width measurement
    width_inc = (pulse_prev_r && (width_r != '1)) ? width_r + 1'b1 : width_r;
    width_nxt      = width_inc;
    pulse_prev_nxt = pulse_prev_r;
    setpt_nxt      = setpt_r;
    if (s1_pulse_r && !pulse_prev_r) begin
      width_nxt      = '0;
      pulse_prev_nxt = 1'b1;
    end else if (!s1_pulse_r && pulse_prev_r) begin
      setpt_nxt      = $signed({1'b0, width_inc}) - $signed({1'b0, offset_r});
      pulse_prev_nxt = 1'b0;
    end

    // sample timing; a zero period samples every tick
    tick_inc = (tick_r != '1) ? tick_r + 1'b1 : tick_r;
    sample   = (tick_inc >= period_r);
    tick_nxt = sample ? '0 : tick_inc;

    // beam output selection: kick, calibration, clamp
    kick_sign_nxt    = kick_sign_r;
    perturb_prev_nxt = perturb_prev_r;
    y_sel            = y_raw;
    if (s1_perturb_r && !perturb_prev_r) begin
      y_sel         = kick_sign_r ? Y_W'(bbpe_pkg::NEG_FULL_SCALE)
                                  : Y_W'(bbpe_pkg::FULL_SCALE);
      kick_sign_nxt = !kick_sign_r;
    end
    if (!s1_calib_r) begin
      y_sel = '0;
    end
    if (y_sel < Y_W'(bbpe_pkg::NEG_FULL_SCALE)) begin
      y_cl = bbpe_pkg::NEG_FULL_SCALE;
    end else if (y_sel > Y_W'(bbpe_pkg::FULL_SCALE)) begin
      y_cl = bbpe_pkg::FULL_SCALE;
    end else begin
      y_cl = y_sel[BEAM_W-1:0];
    end
    y_pos = y_cl + bbpe_pkg::FULL_SCALE;

    // defaults: hold
    xin0_nxt         = xin0_r;
    xin1_nxt         = xin1_r;
    sout0_nxt        = sout0_r;
    sout1_nxt        = sout1_r;
    beam0_nxt        = beam0_r;
    beam1_nxt        = beam1_r;
    applied_beam_nxt = applied_beam_r;
    pwm_nxt          = pwm_r;
    toggle_nxt       = toggle_r;
    pin_nxt          = pin_r;

    if (sample) begin
      pin_nxt          = toggle_r;
      toggle_nxt       = !toggle_r;
      perturb_prev_nxt = s1_perturb_r;
      if (y_cl != applied_beam_r) begin
        applied_beam_nxt = y_cl;
        pwm_nxt          = y_pos[BEAM_W-1:FRAC_BITS];
      end
      xin1_nxt  = xin0_r;
      xin0_nxt  = {setpt_nxt, {FRAC_BITS{1'b0}}};
      sout1_nxt = sout0_r;
      sout0_nxt = sv;
      beam1_nxt = beam0_r;
      beam0_nxt = y_cl;
    end else begin
      kick_sign_nxt = kick_sign_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r         <= '0;
      pulse_prev_r   <= 1'b0;
      width_r        <= '0;
      setpt_r        <= '0;
      xin0_r         <= '0;
      xin1_r         <= '0;
      sout0_r        <= '0;
      sout1_r        <= '0;
      beam0_r        <= '0;
      beam1_r        <= '0;
      applied_beam_r <= '0;
      pwm_r          <= '0;
      kick_sign_r    <= 1'b0;
      perturb_prev_r <= 1'b0;
      toggle_r       <= 1'b0;
      pin_r          <= 1'b0;
      sampled_r      <= 1'b0;
    end else if (load) begin
      tick_r         <= tick_nxt;
      pulse_prev_r   <= pulse_prev_nxt;
      width_r        <= width_nxt;
      setpt_r        <= setpt_nxt;
      xin0_r         <= xin0_nxt;
      xin1_r         <= xin1_nxt;
      sout0_r        <= sout0_nxt;
      sout1_r        <= sout1_nxt;
      beam0_r        <= beam0_nxt;
      beam1_r        <= beam1_nxt;
      applied_beam_r <= applied_beam_nxt;
      pwm_r          <= pwm_nxt;
      kick_sign_r    <= kick_sign_nxt;
      perturb_prev_r <= perturb_prev_nxt;
      toggle_r       <= toggle_nxt;
      pin_r          <= pin_nxt;
      sampled_r      <= sample;
    end
  end

  // --------------------------------------------------------------------------
  // Result ports: state only changes on load, so it holds while stalled
  // --------------------------------------------------------------------------
  assign out_valid         = out_valid_r;
  assign out_pwm_level     = pwm_r;
  assign out_sample_toggle = pin_r;
  assign out_servo_tenths  = bbpe_pkg::to_tenths(sout0_r);
  assign out_sampled       = sampled_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BBPE_ASSERT_SAME(a_beam_in_range, clk, rst_n, 1'b1, (applied_beam_r <= bbpe_pkg::FULL_SCALE) && (applied_beam_r >= bbpe_pkg::NEG_FULL_SCALE))
  `BBPE_ASSERT_NEXT(a_toggle_flips, clk, rst_n, load && sample, toggle_r != $past(toggle_r))
  `BBPE_ASSERT_NEXT(a_pwm_hold, clk, rst_n, !(load && sample), $stable(pwm_r))
  `BBPE_ASSERT_SAME(a_free_stage_ready, clk, rst_n, !s1_valid_r, in_ready)

endmodule

// ----- tb/tb_ball_beam_plant_emulator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ball_beam_plant_emulator
// Self-checking bench for the ball and beam plant emulator. A short table of
// pin patterns (with hand-worked results where they are obvious) is followed
// by pulse trains with random content over several register settings,
// including coefficient extremes and the longest sample period. Hand-worked
// results are checked as given, all others against an in-bench plant model.
// ----------------------------------------------------------------------------

module tb_ball_beam_plant_emulator;

  localparam int PWM_BITS       = bbpe_pkg::PWM_BITS;
  localparam int TENTHS_W       = bbpe_pkg::TENTHS_W;
  localparam int FRAC_BITS      = bbpe_pkg::FRAC_BITS;
  localparam int COEF_FRAC_BITS = bbpe_pkg::COEF_FRAC_BITS;
  localparam int STATE_W        = bbpe_pkg::STATE_W;
  localparam int CNT_W          = bbpe_pkg::CNT_W;
  localparam int CFG_IDX_W      = bbpe_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W     = bbpe_pkg::CFG_DATA_W;

  // One result as the block reports it
  typedef struct packed {
    logic [PWM_BITS-1:0]        pwm;
    logic                       toggle;
    logic signed [TENTHS_W-1:0] tenths;
    logic                       sampled;
  } plant_res_t;

  // One tick request; "given" rows carry a hand-worked result in want
  typedef struct packed {
    logic       pulse;
    logic       perturb;
    logic       calib;
    logic       given;
    plant_res_t want;
  } tick_t;

  localparam longint BEAM_FULL = ((64'sd1 <<< PWM_BITS) - 64'sd1) <<< (FRAC_BITS - 1);
  localparam longint LIM48     = (64'sd1 <<< (STATE_W - 1)) - 64'sd1;
  localparam longint CNT_MAX   = (64'sd1 <<< CNT_W) - 64'sd1;
  localparam int     HOLD_AT   = 150;  // result count that starts the long receiver stall
  localparam int     HOLD_LEN  = 200;

  // Directed table, run with sample_period 1 right after reset so that every
  // tick samples. The first nine rows keep the pulse pin low: setpoint and
  // servo stay at zero and the beam is driven only by kicks, calibration and
  // the double integrator, so results are easy to work out by hand:
  // alternating kick sign, calibration forcing mid scale, clamping at full
  // scale, and the PWM holding when the beam value does not change. The
  // remaining rows (pulses, kick during a pulse, one-tick pulse) go through
  // the model.
  localparam int N_DIRECTED = 23;
  localparam tick_t DIRECTED_TICKS [N_DIRECTED] = '{
    '{1'b0, 1'b0, 1'b1, 1'b1, '{12'd0,    1'b0, 16'sd0, 1'b1}},  // first sample, idle
    '{1'b0, 1'b1, 1'b1, 1'b1, '{12'd4095, 1'b1, 16'sd0, 1'b1}},  // kick, positive
    '{1'b0, 1'b1, 1'b0, 1'b1, '{12'd2047, 1'b0, 16'sd0, 1'b1}},  // held button, calib low
    '{1'b0, 1'b0, 1'b0, 1'b1, '{12'd2047, 1'b1, 16'sd0, 1'b1}},  // y unchanged, pwm holds
    '{1'b0, 1'b1, 1'b1, 1'b1, '{12'd0,    1'b0, 16'sd0, 1'b1}},  // kick, negative
    '{1'b0, 1'b0, 1'b1, 1'b1, '{12'd0,    1'b1, 16'sd0, 1'b1}},  // clamp at -full
    '{1'b0, 1'b1, 1'b0, 1'b1, '{12'd2047, 1'b0, 16'sd0, 1'b1}},  // kick masked by calib
    '{1'b0, 1'b0, 1'b1, 1'b1, '{12'd4095, 1'b1, 16'sd0, 1'b1}},  // integrator to +full
    '{1'b0, 1'b0, 1'b1, 1'b1, '{12'd4095, 1'b0, 16'sd0, 1'b1}},  // clamp at +full
    '{1'b1, 1'b0, 1'b1, 1'b0, '{12'd0, 1'b0, 16'sd0, 1'b0}},     // pulse rise
    '{1'b1, 1'b0, 1'b1, 1'b0, '{12'd0, 1'b0, 16'sd0, 1'b0}},
    '{1'b1, 1'b0, 1'b1, 1'b0, '{12'd0, 1'b0, 16'sd0, 1'b0}},
    '{1'b0, 1'b0, 1'b1, 1'b0, '{12'd0, 1'b0, 16'sd0, 1'b0}},     // fall, negative setpoint
    '{1'b0, 1'b0, 1'b1, 1'b0, '{12'd0, 1'b0, 16'sd0, 1'b0}},
    '{1'b0, 1'b0, 1'b1, 1'b0, '{12'd0, 1'b0, 16'sd0, 1'b0}},
    '{1'b0, 1'b0, 1'b1, 1'b0, '{12'd0, 1'b0, 16'sd0, 1'b0}},
    '{1'b1, 1'b1, 1'b1, 1'b0, '{12'd0, 1'b0, 16'sd0, 1'b0}},     // rise with kick
    '{1'b0, 1'b1, 1'b1, 1'b0, '{12'd0, 1'b0, 16'sd0, 1'b0}},     // one-tick pulse
    '{1'b0, 1'b0, 1'b1, 1'b0, '{12'd0, 1'b0, 16'sd0, 1'b0}},
    '{1'b1, 1'b0, 1'b0, 1'b0, '{12'd0, 1'b0, 16'sd0, 1'b0}},
    '{1'b0, 1'b0, 1'b0, 1'b0, '{12'd0, 1'b0, 16'sd0, 1'b0}},
    '{1'b0, 1'b1, 1'b1, 1'b0, '{12'd0, 1'b0, 16'sd0, 1'b0}},
    '{1'b0, 1'b0, 1'b1, 1'b0, '{12'd0, 1'b0, 16'sd0, 1'b0}}
  };

  // DUT ports; the inputs are known from time zero
  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_pulse_level = 1'b0;
  logic                       in_perturb_level = 1'b0;
  logic                       in_calib_level = 1'b1;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [PWM_BITS-1:0]        out_pwm_level;
  logic                       out_sample_toggle;
  logic signed [TENTHS_W-1:0] out_servo_tenths;
  logic                       out_sampled;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  // Requests waiting to be offered, and results the plant model says are due
  tick_t      ticks_pending[$];
  plant_res_t results_due[$];

  logic no_idle = 1'b0;   // suppresses random gaps on both sides
  int   mismatch_cnt = 0;
  int   result_cnt = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  // Plant model state, at reset values
  longint m_period = 100, m_offset = 510;
  longint m_coef_a = 2265, m_coef_b = -2144728749, m_coef_c = 1070989194, m_coef_e = 29450;
  longint m_ticks = 0, m_width = 0, m_setpt = 0, m_applied = 0;
  longint m_xin[2] = '{0, 0};
  longint m_sout[2] = '{0, 0};
  longint m_beam[2] = '{0, 0};
  bit     m_pulse_prev = 1'b0, m_kick_neg = 1'b0, m_perturb_prev = 1'b0;
  bit     m_toggle = 1'b0, m_pin = 1'b0;
  logic [PWM_BITS-1:0] m_pwm = '0;

  // Pulse train generator state
  bit gen_pulse = 1'b0, gen_perturb = 1'b0;
  int gen_run = 0;

  ball_beam_plant_emulator u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pulse_level    (in_pulse_level),
    .in_perturb_level  (in_perturb_level),
    .in_calib_level    (in_calib_level),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pwm_level     (out_pwm_level),
    .out_sample_toggle (out_sample_toggle),
    .out_servo_tenths  (out_servo_tenths),
    .out_sampled       (out_sampled),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // floor(sum c*s / 2^COEF_FRAC_BITS), saturated to the 48-bit state range.
  // Worked at 96 bits so no split of the state word is needed.
  function automatic longint scaled_sum(input longint c0, s0, c1, s1, c2, s2);
    logic signed [95:0] k0, k1, k2, v0, v1, v2, acc;
    k0 = c0; k1 = c1; k2 = c2;
    v0 = s0; v1 = s1; v2 = s2;
    acc = (k0 * v0 + k1 * v1 + k2 * v2) >>> COEF_FRAC_BITS;
    if (acc > LIM48) return LIM48;
    if (acc < -LIM48 - 1) return -LIM48 - 1;
    return longint'(acc);
  endfunction

  // Advance the plant by one tick and return the result it reports
  function automatic plant_res_t plant_step(input tick_t t);
    plant_res_t r;
    longint sv, y, tenths;
    bit did;
    did = 1'b0;

    // pulse width capture
    if (m_pulse_prev && m_width < CNT_MAX) m_width++;
    if (t.pulse && !m_pulse_prev) begin
      m_width = 0;
      m_pulse_prev = 1'b1;
    end else if (!t.pulse && m_pulse_prev) begin
      m_setpt = m_width - m_offset;
      m_pulse_prev = 1'b0;
    end

    if (m_ticks < CNT_MAX) m_ticks++;
    if (m_ticks >= m_period) begin
      m_ticks = 0;
      did = 1'b1;
      m_pin = m_toggle;
      m_toggle = !m_toggle;

      sv = scaled_sum(m_coef_a, m_xin[1], -m_coef_b, m_sout[0], -m_coef_c, m_sout[1]);
      y = 2 * m_beam[0] - m_beam[1] + scaled_sum(m_coef_e, m_sout[1], 0, 0, 0, 0);

      // button edge is judged against the level seen at the previous sample
      if (t.perturb && !m_perturb_prev) begin
        y = m_kick_neg ? -BEAM_FULL : BEAM_FULL;
        m_kick_neg = !m_kick_neg;
      end
      m_perturb_prev = t.perturb;
      if (!t.calib) y = 0;
      if (y < -BEAM_FULL) y = -BEAM_FULL;
      if (y > BEAM_FULL) y = BEAM_FULL;

      if (y != m_applied) begin
        m_applied = y;
        m_pwm = PWM_BITS'((y + BEAM_FULL) >>> FRAC_BITS);
      end

      m_xin[1] = m_xin[0];
      m_xin[0] = m_setpt * (64'sd1 <<< FRAC_BITS);
      m_sout[1] = m_sout[0];
      m_sout[0] = sv;
      m_beam[1] = m_beam[0];
      m_beam[0] = y;
    end

    // truncation toward zero, as longint division does
    tenths = (m_sout[0] * 10) / (64'sd1 <<< FRAC_BITS);
    if (tenths > 32767) tenths = 32767;
    if (tenths < -32768) tenths = -32768;

    r.pwm     = m_pwm;
    r.toggle  = m_pin;
    r.tenths  = tenths[TENTHS_W-1:0];
    r.sampled = did;
    return r;
  endfunction

  // Pulse trains with random widths, button presses and short calibration
  // drops; about one tick in ten is pure noise on all three pins.
  function automatic tick_t next_random_tick();
    tick_t t;
    t = '0;
    if ($urandom_range(0, 9) == 0) begin
      {t.pulse, t.perturb, t.calib} = 3'($urandom);
    end else begin
      if (gen_run == 0) begin
        gen_pulse = !gen_pulse;
        if (!gen_pulse) gen_run = $urandom_range(1, 40);
        else if ($urandom_range(0, 15) == 0) gen_run = $urandom_range(400, 620);
        else gen_run = $urandom_range(1, 60);
      end
      gen_run--;
      if ($urandom_range(0, 7) == 0) gen_perturb = !gen_perturb;
      t.pulse   = gen_pulse;
      t.perturb = gen_perturb;
      t.calib   = $urandom_range(0, 9) != 0;
    end
    return t;
  endfunction

  // Sender: offers the oldest pending tick, with random gaps. Once valid is
  // up it stays up with the same payload until the request is taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (ticks_pending[0].given) begin
          void'(plant_step(ticks_pending[0]));
          results_due.push_back(ticks_pending[0].want);
        end else begin
          results_due.push_back(plant_step(ticks_pending[0]));
        end
        void'(ticks_pending.pop_front());
      end
      if (!(in_valid && !in_ready)) begin
        if (ticks_pending.size() != 0 && (no_idle || $urandom_range(0, 99) >= 6)) begin
          in_valid         <= 1'b1;
          in_pulse_level   <= ticks_pending[0].pulse;
          in_perturb_level <= ticks_pending[0].perturb;
          in_calib_level   <= ticks_pending[0].calib;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result against the oldest one due. After HOLD_AT
  // results it holds ready low until hold_left, loaded from HOLD_LEN, runs out,
  // so both stages fill and the input side backs up.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          if (mismatch_cnt < 10) begin
            $display("unexpected result %0d: pwm %0d toggle %0b tenths %0d sampled %0b",
                     result_cnt, out_pwm_level, out_sample_toggle,
                     out_servo_tenths, out_sampled);
          end
          mismatch_cnt++;
        end else if (results_due[0] !== {out_pwm_level, out_sample_toggle,
                                         out_servo_tenths, out_sampled}) begin
          if (mismatch_cnt < 10) begin
            $display({"mismatch at result %0d: pwm %0d/%0d toggle %0b/%0b",
                      " tenths %0d/%0d sampled %0b/%0b (exp/act)"},
                     result_cnt, results_due[0].pwm, out_pwm_level,
                     results_due[0].toggle, out_sample_toggle,
                     results_due[0].tenths, out_servo_tenths,
                     results_due[0].sampled, out_sampled);
          end
          mismatch_cnt++;
          void'(results_due.pop_front());
        end else begin
          void'(results_due.pop_front());
        end
        result_cnt++;
      end
      if (!hold_done && result_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || $urandom_range(0, 99) >= 6;
      end
    end
  end

  // Writes all six registers in map order and mirrors them into the model.
  // Only called with nothing in flight.
  task automatic program_regs(input logic [31:0] period, offset, ca, cb, cc, ce);
    logic [31:0] vals [6];
    logic [CFG_IDX_W-1:0] regs [6];
    vals = '{period, offset, ca, cb, cc, ce};
    regs = '{bbpe_pkg::CFG_SAMPLE_PERIOD, bbpe_pkg::CFG_PULSE_OFFSET,
             bbpe_pkg::CFG_COEF_A, bbpe_pkg::CFG_COEF_B,
             bbpe_pkg::CFG_COEF_C, bbpe_pkg::CFG_COEF_E};
    for (int i = 0; i < 6; i++) begin
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      unique case (regs[i])
        bbpe_pkg::CFG_SAMPLE_PERIOD: m_period = vals[i][CNT_W-1:0];
        bbpe_pkg::CFG_PULSE_OFFSET:  m_offset = vals[i][CNT_W-1:0];
        bbpe_pkg::CFG_COEF_A:        m_coef_a = $signed(vals[i]);
        bbpe_pkg::CFG_COEF_B:        m_coef_b = $signed(vals[i]);
        bbpe_pkg::CFG_COEF_C:        m_coef_c = $signed(vals[i]);
        bbpe_pkg::CFG_COEF_E:        m_coef_e = $signed(vals[i]);
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Waits until every queued tick is taken and every result has come back
  task automatic drain_results();
    do @(posedge clk); while (ticks_pending.size() != 0 || results_due.size() != 0);
  endtask

  task automatic feed_random(input int n);
    repeat (n) ticks_pending.push_back(next_random_tick());
    drain_results();
  endtask

  initial begin
    tick_t t;
    logic [31:0] ra, rb, rc, re;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, one sample per tick, everything else at reset values
    program_regs(32'd1, bbpe_pkg::PULSE_OFFSET_RST, bbpe_pkg::COEF_A_RST,
                 bbpe_pkg::COEF_B_RST, bbpe_pkg::COEF_C_RST, bbpe_pkg::COEF_E_RST);
    foreach (DIRECTED_TICKS[i]) ticks_pending.push_back(DIRECTED_TICKS[i]);
    drain_results();

    // nominal plant; the long receiver stall lands in here
    program_regs(bbpe_pkg::SAMPLE_PERIOD_RST, bbpe_pkg::PULSE_OFFSET_RST,
                 bbpe_pkg::COEF_A_RST, bbpe_pkg::COEF_B_RST,
                 bbpe_pkg::COEF_C_RST, bbpe_pkg::COEF_E_RST);
    feed_random(200);

    // back-to-back traffic, no gaps on either side
    no_idle <= 1'b1;
    program_regs(32'd1, 32'd0, bbpe_pkg::COEF_A_RST, bbpe_pkg::COEF_B_RST,
                 bbpe_pkg::COEF_C_RST, bbpe_pkg::COEF_E_RST);
    feed_random(150);
    no_idle <= 1'b0;

    // coefficient extremes drive the servo and tenths into saturation;
    // largest offset gives the most negative setpoints
    program_regs(32'd7, 32'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    feed_random(100);
    program_regs(32'd3, 32'($urandom_range(0, 65535)), 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000);
    feed_random(100);

    // random coefficients; then the period drops below the running tick
    // count, which must sample on the very next tick
    ra = $urandom; rb = $urandom; rc = $urandom; re = $urandom;
    program_regs(32'd400, bbpe_pkg::PULSE_OFFSET_RST, ra, rb, rc, re);
    feed_random(120);
    program_regs(32'd2, 32'($urandom_range(0, 65535)), $urandom, $urandom, $urandom, $urandom);
    feed_random(120);

    // longest period: a pulse is captured with no sample in between, then a
    // short period so the captured setpoint works through the servo
    program_regs(32'hFFFF, 32'd0, bbpe_pkg::COEF_A_RST, bbpe_pkg::COEF_B_RST,
                 bbpe_pkg::COEF_C_RST, bbpe_pkg::COEF_E_RST);
    t = '0;
    t.calib = 1'b1;
    t.pulse = 1'b1;
    repeat (30) begin
      t.perturb = $urandom_range(0, 1);
      ticks_pending.push_back(t);
    end
    t.pulse = 1'b0;
    repeat (10) ticks_pending.push_back(t);
    drain_results();
    program_regs(32'd5, 32'd0, bbpe_pkg::COEF_A_RST, bbpe_pkg::COEF_B_RST,
                 bbpe_pkg::COEF_C_RST, bbpe_pkg::COEF_E_RST);
    feed_random(50);

    // let anything stray come out before judging
    repeat (4) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run (about a thousand ticks
  // plus the receiver stall and register writes)
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- ball_beam_plant_emulator.f -----
+incdir+rtl
rtl/bbpe_pkg.sv
rtl/ball_beam_plant_emulator.sv
tb/tb_ball_beam_plant_emulator.sv
